/* sv/triangle_edge_setup_unit_macros.svh */
// Assertion macros for the triangle edge setup unit.
// Expects clk and arst_n in the scope of each use.
`ifndef TRIANGLE_EDGE_SETUP_UNIT_MACROS_SVH
`define TRIANGLE_EDGE_SETUP_UNIT_MACROS_SVH

// Check a property on every clock once reset is released.
`define TES_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition implies another in the same cycle.
`define TES_ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

/* sv/tes_pkg.sv */
// Package for the triangle edge setup unit: widths, register codes, types
// and the ceiling and clamp helpers. No dependencies.
`timescale 1ns / 1ps

package tes_pkg;

	localparam int FRAC_BITS = 8;
	localparam int COORD_W   = 24;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int AREA_W    = 52;
	localparam int TAREA_W   = 51;
	localparam int DIM_W     = 13;
	localparam int OFS_W     = 27;
	localparam int MUL_W     = DIFF_W + OFS_W;
	localparam int START_W   = 52;
	localparam int STEP_W    = 25;
	localparam int IN_W      = 6 * COORD_W;
	localparam int OUT_W     = 208;
	localparam int USER_W    = 3;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic [DIM_W-1:0]   SCREEN_MAX = DIM_W'(4096);
	localparam logic [COORD_W-1:0] FRAC_MASK  = COORD_W'((1 << FRAC_BITS) - 1);

	localparam logic [1:0] CULL_NONE = 2'd0;
	localparam logic [1:0] CULL_POS  = 2'd1;
	localparam logic [1:0] CULL_NEG  = 2'd2;

	localparam logic [1:0] EDGE_AB = 2'd0;
	localparam logic [1:0] EDGE_BC = 2'd1;
	localparam logic [1:0] EDGE_CA = 2'd2;

	localparam logic [DIM_W-1:0]   SCREEN_W_RST = DIM_W'(640);
	localparam logic [DIM_W-1:0]   SCREEN_H_RST = DIM_W'(480);
	localparam logic [COORD_W-1:0] VIEW_XMAX_RST = COORD_W'(640 << FRAC_BITS);
	localparam logic [COORD_W-1:0] VIEW_YMAX_RST = COORD_W'(480 << FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CULL_MODE,
		REG_SCREEN_WIDTH,
		REG_SCREEN_HEIGHT,
		REG_VIEW_X_MIN,
		REG_VIEW_Y_MIN,
		REG_VIEW_X_MAX,
		REG_VIEW_Y_MAX
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0] left;
		logic [DIM_W-1:0] top;
		logic [DIM_W-1:0] right;
		logic [DIM_W-1:0] bottom;
	} box_t;

	typedef struct packed {
		logic               acc;
		logic [1:0]         idx;
		logic               last;
		logic               swapped;
		box_t               box;
		logic [TAREA_W-1:0] area;
	} edge_meta_t;

	function automatic logic signed [COORD_W-1:0] min3(input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b, input logic signed [COORD_W-1:0] c);
		logic signed [COORD_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [COORD_W-1:0] max3(input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b, input logic signed [COORD_W-1:0] c);
		logic signed [COORD_W-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic logic [DIM_W-1:0] screen_dim(input logic [DIM_W-1:0] r);
		return (r > SCREEN_MAX) ? SCREEN_MAX : r;
	endfunction

	// ceil(v / 2^FRAC_BITS) clamped to [0, lim]
	function automatic logic [DIM_W-1:0] ceil_clamp(input logic signed [COORD_W-1:0] v,
		input logic [DIM_W-1:0] lim);
		logic signed [COORD_W:0] s;
		logic signed [COORD_W:0] c;
		logic signed [COORD_W:0] l;
		s = $signed({v[COORD_W-1], v}) + $signed({1'b0, FRAC_MASK});
		c = s >>> FRAC_BITS;
		l = $signed({{(COORD_W + 1 - DIM_W){1'b0}}, lim});
		if (c < 0) begin
			return '0;
		end else if (c > l) begin
			return lim;
		end
		return c[DIM_W-1:0];
	endfunction

endpackage

/* sv/triangle_edge_setup_unit.sv */
// Triangle edge setup: area, culling, bounding box and edge functions.
// One request per cycle enters while s_axis_tready is high; the edge sequencer
// emits 3 results per accepted triangle and 1 per rejected one, so an accepted
// triangle holds stage 4 and stalls the input until its last edge is issued; m_axis_tready also stalls the pipeline.
// Reset clears all valid bits and loads the register defaults.
// Depends on tes_pkg and triangle_edge_setup_unit_macros.svh.
`timescale 1ns / 1ps

`include "triangle_edge_setup_unit_macros.svh"

module triangle_edge_setup_unit
	import tes_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_W-1:0]      s_axis_tdata,  // ax, ay, bx, by, cx, cy
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// edge_start, step_x, step_y, box_left, box_top, box_right, box_bottom,
	// twice_area, swapped, zero fill
	output logic [OUT_W-1:0]     m_axis_tdata,
	output logic [USER_W-1:0]    m_axis_tuser,  // accepted, edge_index
	output logic                 m_axis_tlast
);

	logic [1:0]                cull_mode_q;
	logic [DIM_W-1:0]          screen_width_q, screen_height_q;
	logic signed [COORD_W-1:0] view_x_min_q, view_y_min_q, view_x_max_q, view_y_max_q;
	logic [DIM_W-1:0]          dim_w_q, dim_h_q;
	box_t                      vp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_mode_q     <= CULL_NONE;
			screen_width_q  <= SCREEN_W_RST;
			screen_height_q <= SCREEN_H_RST;
			view_x_min_q    <= '0;
			view_y_min_q    <= '0;
			view_x_max_q    <= VIEW_XMAX_RST;
			view_y_max_q    <= VIEW_YMAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CULL_MODE:     cull_mode_q     <= cfg_wdata[1:0];
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata[DIM_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata[DIM_W-1:0];
				REG_VIEW_X_MIN:    view_x_min_q    <= cfg_wdata;
				REG_VIEW_Y_MIN:    view_y_min_q    <= cfg_wdata;
				REG_VIEW_X_MAX:    view_x_max_q    <= cfg_wdata;
				REG_VIEW_Y_MAX:    view_y_max_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// screen-clamped viewport, derived from the registers
	always_ff @(posedge clk) begin
		dim_w_q      <= screen_dim(screen_width_q);
		dim_h_q      <= screen_dim(screen_height_q);
		vp_q.left    <= ceil_clamp(view_x_min_q, screen_dim(screen_width_q));
		vp_q.top     <= ceil_clamp(view_y_min_q, screen_dim(screen_height_q));
		vp_q.right   <= ceil_clamp(view_x_max_q, screen_dim(screen_width_q));
		vp_q.bottom  <= ceil_clamp(view_y_max_q, screen_dim(screen_height_q));
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;
	logic fire4, last_tok, done4;

	assign en7   = !v_s7 || m_axis_tready;
	assign en6   = !v_s6 || en7;
	assign en5   = !v_s5 || en6;
	assign fire4 = v_s4 && en5;
	assign done4 = fire4 && last_tok;
	assign en4   = !v_s4 || done4;
	assign en3   = !v_s3 || en4;
	assign en2   = !v_s2 || en3;
	assign en1   = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// stage 1: vertex differences and extremes
	logic signed [COORD_W-1:0] vx_in [3];
	logic signed [COORD_W-1:0] vy_in [3];
	logic signed [COORD_W-1:0] vx_s1 [3];
	logic signed [COORD_W-1:0] vy_s1 [3];
	logic signed [DIFF_W-1:0]  dbx_s1, dcy_s1, dby_s1, dcx_s1;
	logic signed [COORD_W-1:0] xmin_s1, xmax_s1, ymin_s1, ymax_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vx_in[i] = s_axis_tdata[2 * i * COORD_W +: COORD_W];
			vy_in[i] = s_axis_tdata[(2 * i + 1) * COORD_W +: COORD_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			vx_s1   <= vx_in;
			vy_s1   <= vy_in;
			dbx_s1  <= DIFF_W'(vx_in[1]) - DIFF_W'(vx_in[0]);
			dcy_s1  <= DIFF_W'(vy_in[2]) - DIFF_W'(vy_in[0]);
			dby_s1  <= DIFF_W'(vy_in[1]) - DIFF_W'(vy_in[0]);
			dcx_s1  <= DIFF_W'(vx_in[2]) - DIFF_W'(vx_in[0]);
			xmin_s1 <= min3(vx_in[0], vx_in[1], vx_in[2]);
			xmax_s1 <= max3(vx_in[0], vx_in[1], vx_in[2]);
			ymin_s1 <= min3(vy_in[0], vy_in[1], vy_in[2]);
			ymax_s1 <= max3(vy_in[0], vy_in[1], vy_in[2]);
		end
	end

	// stage 2: area products and clipped box
	logic signed [COORD_W-1:0] vx_s2 [3];
	logic signed [COORD_W-1:0] vy_s2 [3];
	logic signed [PROD_W-1:0]  p1_s2, p2_s2;
	box_t                      box_s2;
	logic [DIM_W-1:0]          bl_c, bt_c, br_c, bb_c;

	always_comb begin
		bl_c = ceil_clamp(xmin_s1, dim_w_q);
		bt_c = ceil_clamp(ymin_s1, dim_h_q);
		br_c = ceil_clamp(xmax_s1, dim_w_q);
		bb_c = ceil_clamp(ymax_s1, dim_h_q);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			vx_s2         <= vx_s1;
			vy_s2         <= vy_s1;
			p1_s2         <= dbx_s1 * dcy_s1;
			p2_s2         <= dby_s1 * dcx_s1;
			box_s2.left   <= (vp_q.left > bl_c) ? vp_q.left : bl_c;
			box_s2.top    <= (vp_q.top > bt_c) ? vp_q.top : bt_c;
			box_s2.right  <= (vp_q.right < br_c) ? vp_q.right : br_c;
			box_s2.bottom <= (vp_q.bottom < bb_c) ? vp_q.bottom : bb_c;
		end
	end

	// stage 3: signed area and box test
	logic signed [COORD_W-1:0] vx_s3 [3];
	logic signed [COORD_W-1:0] vy_s3 [3];
	logic signed [AREA_W-1:0]  area_s3;
	box_t                      box_s3;
	logic                      box_ok_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			vx_s3     <= vx_s2;
			vy_s3     <= vy_s2;
			area_s3   <= AREA_W'(p1_s2) - AREA_W'(p2_s2);
			box_s3    <= box_s2;
			box_ok_s3 <= (box_s2.left < box_s2.right) && (box_s2.top < box_s2.bottom);
		end
	end

	// stage 4: cull, winding fix, edge sequencer
	logic signed [COORD_W-1:0] vx_s4 [3];
	logic signed [COORD_W-1:0] vy_s4 [3];
	logic [TAREA_W-1:0]        area_s4;
	box_t                      box_s4;
	logic                      acc_s4, swapped_s4;
	logic [1:0]                cnt_q;
	logic                      neg_c, rej_c;
	logic signed [AREA_W-1:0]  abs_c;

	always_comb begin
		neg_c = area_s3[AREA_W-1];
		abs_c = neg_c ? -area_s3 : area_s3;
		rej_c = (area_s3 == '0) || ((cull_mode_q == CULL_POS) && !neg_c) ||
			((cull_mode_q == CULL_NEG) && neg_c) || !box_ok_s3;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			vx_s4[0]   <= vx_s3[0];
			vy_s4[0]   <= vy_s3[0];
			vx_s4[1]   <= neg_c ? vx_s3[2] : vx_s3[1];
			vy_s4[1]   <= neg_c ? vy_s3[2] : vy_s3[1];
			vx_s4[2]   <= neg_c ? vx_s3[1] : vx_s3[2];
			vy_s4[2]   <= neg_c ? vy_s3[1] : vy_s3[2];
			area_s4    <= abs_c[TAREA_W-1:0];
			box_s4     <= box_s3;
			acc_s4     <= !rej_c;
			swapped_s4 <= neg_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= EDGE_AB;
		end else if (fire4) begin
			cnt_q <= last_tok ? EDGE_AB : cnt_q + 2'd1;
		end
	end

	logic signed [COORD_W-1:0] sx_c, sy_c, ex_c, ey_c;
	logic signed [DIFF_W-1:0]  dx_c, dy_c;
	logic signed [OFS_W-1:0]   ty_c, lx_c;

	assign last_tok = !acc_s4 || (cnt_q == EDGE_CA);

	always_comb begin
		unique case (cnt_q)
			EDGE_AB: begin
				sx_c = vx_s4[0]; sy_c = vy_s4[0]; ex_c = vx_s4[1]; ey_c = vy_s4[1];
			end
			EDGE_BC: begin
				sx_c = vx_s4[1]; sy_c = vy_s4[1]; ex_c = vx_s4[2]; ey_c = vy_s4[2];
			end
			default: begin
				sx_c = vx_s4[2]; sy_c = vy_s4[2]; ex_c = vx_s4[0]; ey_c = vy_s4[0];
			end
		endcase
		dx_c = DIFF_W'(ex_c) - DIFF_W'(sx_c);
		dy_c = DIFF_W'(ey_c) - DIFF_W'(sy_c);
		ty_c = $signed(OFS_W'(box_s4.top) << FRAC_BITS) - OFS_W'(sy_c);
		lx_c = $signed(OFS_W'(box_s4.left) << FRAC_BITS) - OFS_W'(sx_c);
	end

	// stage 5: one edge's operands
	logic signed [DIFF_W-1:0] dx_s5, dy_s5;
	logic signed [OFS_W-1:0]  ty_s5, lx_s5;
	edge_meta_t               meta_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			dx_s5           <= dx_c;
			dy_s5           <= dy_c;
			ty_s5           <= ty_c;
			lx_s5           <= lx_c;
			meta_s5.acc     <= acc_s4;
			meta_s5.idx     <= cnt_q;
			meta_s5.last    <= last_tok;
			meta_s5.swapped <= swapped_s4;
			meta_s5.box     <= box_s4;
			meta_s5.area    <= area_s4;
		end
	end

	// stage 6: edge products
	logic signed [DIFF_W-1:0] dx_s6, dy_s6;
	logic signed [MUL_W-1:0]  m1_s6, m2_s6;
	edge_meta_t               meta_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			dx_s6   <= dx_s5;
			dy_s6   <= dy_s5;
			m1_s6   <= dx_s5 * ty_s5;
			m2_s6   <= dy_s5 * lx_s5;
			meta_s6 <= meta_s5;
		end
	end

	// stage 7: output register, rejected triangles carry zeros
	logic                     acc_s7, last_s7, swapped_s7;
	logic [1:0]               idx_s7;
	logic [START_W-1:0]       start_s7;
	logic [STEP_W-1:0]        stepx_s7, stepy_s7;
	box_t                     box_s7;
	logic [TAREA_W-1:0]       area_s7;
	logic signed [MUL_W-1:0]  start_c;
	logic signed [DIFF_W-1:0] ndy_c;

	assign start_c = m1_s6 - m2_s6;
	assign ndy_c   = -dy_s6;

	always_ff @(posedge clk) begin
		if (en7) begin
			acc_s7  <= meta_s6.acc;
			last_s7 <= meta_s6.last;
			if (meta_s6.acc) begin
				idx_s7     <= meta_s6.idx;
				start_s7   <= START_W'(start_c);
				stepx_s7   <= STEP_W'(ndy_c);
				stepy_s7   <= STEP_W'(dx_s6);
				box_s7     <= meta_s6.box;
				area_s7    <= meta_s6.area;
				swapped_s7 <= meta_s6.swapped;
			end else begin
				idx_s7     <= EDGE_AB;
				start_s7   <= '0;
				stepx_s7   <= '0;
				stepy_s7   <= '0;
				box_s7     <= '0;
				area_s7    <= '0;
				swapped_s7 <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = v_s7;
	assign m_axis_tlast  = last_s7;
	assign m_axis_tuser  = {idx_s7, acc_s7};
	assign m_axis_tdata  = {2'b00, swapped_s7, area_s7, box_s7.bottom, box_s7.right,
		box_s7.top, box_s7.left, stepy_s7, stepx_s7, start_s7};

	`TES_ASSERT_IMPLY(a_cnt_owner, cnt_q != EDGE_AB, v_s4 && acc_s4, "edge counter moved without an accepted triangle")
	`TES_ASSERT(a_seq_hold, (fire4 && !last_tok) |=> (v_s4 && acc_s4), "sequencer dropped a triangle before its last edge")
	`TES_ASSERT_IMPLY(a_rej_last, v_s7 && !acc_s7, last_s7 && (area_s7 == '0), "rejected result not single or not cleared")
	`TES_ASSERT_IMPLY(a_acc_area, v_s7 && acc_s7, area_s7 != '0, "accepted result with zero area")
	`TES_ASSERT_IMPLY(a_acc_box, v_s7 && acc_s7, (box_s7.left < box_s7.right) && (box_s7.top < box_s7.bottom), "accepted result with empty box")

endmodule
